FILE: sv/ddq_pkg.sv
// shared types and constants for the double-ended queue unit
`timescale 1ns / 1ps

package ddq_pkg;

  localparam int unsigned DEPTH_DEF = 256;
  localparam int unsigned WORD_W    = 32;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5,
    REQ_CLEAR      = 3'd6
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } fsm_state_t;

endpackage

FILE: sv/ddq_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps

module ddq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: sv/double_ended_queue_unit.sv
// double-ended queue of signed words kept in a ring of ram slots
//
//   channel | direction | handshake          | payload
//   in_     | slave     | in_tvalid/tready   | tuser request kind, tdata push word
//   out_    | master    | out_tvalid/tready  | tuser status, tdata read word
//
// push, clear, unknown and failed requests produce their result in the cycle after acceptance
// pops and peeks that hit pass through the ram read, then the result register
// one request in flight at a time, set by the single ram port and its read latency
// synchronous active-low reset clears front index, count and control; slots are not cleared
// a waiting result stalls new requests only until it is taken
`timescale 1ns / 1ps

module double_ended_queue_unit #(
  parameter int unsigned DEPTH = ddq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // push_value[31:0]
  input  logic [7:0]  in_tuser,   // req_type[2:0], zeros above
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_value[31:0]
  output logic [7:0]  out_tuser   // status[1:0], zeros above
);

  import ddq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  fsm_state_t  state_r, state_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_data_r, out_data_nxt;
  status_t     out_status_r, out_status_nxt;

  req_type_t     req;
  logic          in_fire, full, empty, read_hit;
  logic [AW-1:0] front_dec, front_inc, tail_pos, last_pos;
  logic [SW-1:0] tail_sum, last_sum;
  logic          ram_en, ram_we;
  logic [AW-1:0] ram_addr;
  logic [WORD_W-1:0] ram_rdata;
  status_t       status_now;

  function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] x);
    logic [SW-1:0] y;
    y = (x >= SW'(DEPTH)) ? (x - SW'(DEPTH)) : x;
    return y[AW-1:0];
  endfunction

  assign req      = req_type_t'(in_tuser[2:0]);
  assign in_fire  = in_tvalid && in_tready;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign read_hit = !empty && (req inside {REQ_POP_FRONT, REQ_POP_BACK,
                                           REQ_PEEK_FRONT, REQ_PEEK_BACK});

  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : (front_r - AW'(1));
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : (front_r + AW'(1));
  assign tail_sum  = SW'(front_r) + SW'(count_r);
  assign last_sum  = tail_sum - SW'(1);
  assign tail_pos  = wrap_idx(tail_sum);
  assign last_pos  = wrap_idx(last_sum);

  ddq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_tdata),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && read_hit) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_tready  = 1'b0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = front_r;
    front_nxt  = front_r;
    count_nxt  = count_r;
    status_now = ST_OK;
    case (state_r)
      S_IDLE: begin
        in_tready = !out_valid_r || out_tready;
        if (in_fire) begin
          case (req)
            REQ_PUSH_FRONT: begin
              if (full) begin
                status_now = ST_FULL;
              end else begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            REQ_PUSH_BACK: begin
              if (full) begin
                status_now = ST_FULL;
              end else begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = tail_pos;
                count_nxt = count_r + CW'(1);
              end
            end
            REQ_POP_FRONT, REQ_PEEK_FRONT: begin
              if (empty) begin
                status_now = ST_EMPTY;
              end else begin
                ram_en   = 1'b1;
                ram_addr = front_r;
                if (req == REQ_POP_FRONT) begin
                  front_nxt = front_inc;
                  count_nxt = count_r - CW'(1);
                end
              end
            end
            REQ_POP_BACK, REQ_PEEK_BACK: begin
              if (empty) begin
                status_now = ST_EMPTY;
              end else begin
                ram_en   = 1'b1;
                ram_addr = last_pos;
                if (req == REQ_POP_BACK) begin
                  count_nxt = count_r - CW'(1);
                end
              end
            end
            REQ_CLEAR: begin
              front_nxt = '0;
              count_nxt = '0;
            end
            default: begin
              status_now = ST_OK;
            end
          endcase
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    if (state_r == S_READ) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = ram_rdata;
      out_status_nxt = ST_OK;
    end else if (in_fire && !read_hit) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = '0;
      out_status_nxt = status_now;
    end else if (out_tready) begin
      out_valid_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {6'd0, out_status_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= AW'(DEPTH - 1))
    else $error("front index out of range");

  a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && read_hit |=> state_r == S_READ && !out_valid_r)
    else $error("read request did not enter read wait");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> out_valid_r && out_status_r == ST_OK)
    else $error("read result not delivered");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_data_r == '0)
    else $error("failed request carries nonzero data");

endmodule
